### rtl/numeric_literal_scanner_macros.svh
// ----------------------------------------------------------------------------
// numeric_literal_scanner_macros.svh
// Assertion macros for the numeric literal scanner; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_SCANNER_MACROS_SVH
`define NUMERIC_LITERAL_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define NLS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define NLS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NLS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define NLS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// Shared types and constants of the numeric literal scanner.
// ----------------------------------------------------------------------------
package nls_pkg;

  localparam int CH_W       = 8;
  localparam int VALUE_W    = 31;
  localparam int LEN_W      = 8;
  localparam int KIND_W     = 3;
  localparam int OUT_DATA_W = 40;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};

  // queue between classifier and scanner, depth a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // character codes
  localparam logic [CH_W-1:0] CH_0    = 8'h30;
  localparam logic [CH_W-1:0] CH_9    = 8'h39;
  localparam logic [CH_W-1:0] CH_DOT  = 8'h2e;
  localparam logic [CH_W-1:0] CH_US   = 8'h5f;
  localparam logic [CH_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CH_W-1:0] CH_F_LO = 8'h66;
  localparam logic [CH_W-1:0] CH_Z_LO = 8'h7a;
  localparam logic [CH_W-1:0] CH_A_UP = 8'h41;
  localparam logic [CH_W-1:0] CH_F_UP = 8'h46;
  localparam logic [CH_W-1:0] CH_Z_UP = 8'h5a;
  localparam logic [CH_W-1:0] CH_B_LO = 8'h62;
  localparam logic [CH_W-1:0] CH_B_UP = 8'h42;
  localparam logic [CH_W-1:0] CH_O_LO = 8'h6f;
  localparam logic [CH_W-1:0] CH_O_UP = 8'h4f;
  localparam logic [CH_W-1:0] CH_X_LO = 8'h78;
  localparam logic [CH_W-1:0] CH_X_UP = 8'h58;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEC   = 3'd0,
    KIND_BIN   = 3'd1,
    KIND_OCT   = 3'd2,
    KIND_HEX   = 3'd3,
    KIND_FLOAT = 3'd4,
    KIND_ERR   = 3'd5,
    KIND_NAN   = 3'd6
  } kind_t;

  // one classified character
  typedef struct packed {
    logic [3:0] dig;
    logic       is_dec;
    logic       is_hex;
    logic       is_zero;
    logic       is_b;
    logic       is_o;
    logic       is_x;
    logic       is_us;
    logic       is_dot;
    logic       is_ident;
    logic       last;
  } cls_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

### rtl/nls_front.sv
// ----------------------------------------------------------------------------
// nls_front
// Accepts characters and classifies them into queue entries.
// ----------------------------------------------------------------------------
module nls_front (
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // ch
  input  logic                     in_tlast,
  input  nls_pkg::qstat_t          q_stat,
  output logic                     q_push,
  output nls_pkg::cls_t            q_wdata
);
  import nls_pkg::*;

  logic [CH_W-1:0] ch;
  logic            lower, upper, hex_let;

  assign ch        = in_tdata;
  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && !q_stat.full;

  always_comb begin
    lower   = (ch >= CH_A_LO) && (ch <= CH_Z_LO);
    upper   = (ch >= CH_A_UP) && (ch <= CH_Z_UP);
    hex_let = ((ch >= CH_A_LO) && (ch <= CH_F_LO)) || ((ch >= CH_A_UP) && (ch <= CH_F_UP));

    q_wdata.is_dec   = (ch >= CH_0) && (ch <= CH_9);
    q_wdata.is_hex   = q_wdata.is_dec || hex_let;
    // letters a-f sit at low nibble 1..6 in both cases
    q_wdata.dig      = q_wdata.is_dec ? ch[3:0] : (hex_let ? 4'(ch[3:0] + 4'd9) : 4'd0);
    q_wdata.is_zero  = (ch == CH_0);
    q_wdata.is_b     = (ch == CH_B_LO) || (ch == CH_B_UP);
    q_wdata.is_o     = (ch == CH_O_LO) || (ch == CH_O_UP);
    q_wdata.is_x     = (ch == CH_X_LO) || (ch == CH_X_UP);
    q_wdata.is_us    = (ch == CH_US);
    q_wdata.is_dot   = (ch == CH_DOT);
    q_wdata.is_ident = lower || upper || (ch == CH_US);
    q_wdata.last     = in_tlast;
  end

endmodule

### rtl/nls_queue.sv
// ----------------------------------------------------------------------------
// nls_queue
// Short queue of classified characters between classifier and scanner.
// ----------------------------------------------------------------------------
module nls_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_push,
  input  nls_pkg::cls_t   q_wdata,
  input  logic            q_pop,
  output nls_pkg::cls_t   q_rdata,
  output nls_pkg::qstat_t q_stat
);
  import nls_pkg::*;

  cls_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = q_push ? Q_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? Q_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (q_push && !q_pop) begin
      count_nxt = Q_CW'(count_r + 1'b1);
    end else if (q_pop && !q_push) begin
      count_nxt = Q_CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  assign q_rdata      = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == Q_CW'(Q_DEPTH));

endmodule

### rtl/nls_back.sv
// ----------------------------------------------------------------------------
// nls_back
// Literal scanner: runs the scan state per character and registers results.
// ----------------------------------------------------------------------------
module nls_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nls_pkg::qstat_t                 q_stat,
  input  nls_pkg::cls_t                   q_rdata,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nls_pkg::OUT_DATA_W-1:0]  out_tdata,  // value, length, stopped_by_delimiter
  output logic [nls_pkg::KIND_W-1:0]      out_tuser   // kind
);
  import nls_pkg::*;

  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_ZERO  = 7'b0000010,
    PH_PFX   = 7'b0000100,
    PH_RDIG  = 7'b0001000,
    PH_LEADZ = 7'b0010000,
    PH_DDIG  = 7'b0100000,
    PH_FRAC  = 7'b1000000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  kind_t              radix_r, radix_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r;
  logic [VALUE_W-1:0] out_val_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_stop_r;

  cls_t               c;
  kind_t              mac_kind;
  logic [35:0]        acc_w, prod, sum;
  logic [VALUE_W-1:0] mac_val;
  logic [LEN_W-1:0]   cnt_inc;
  logic               d_ok;

  logic               emit;
  kind_t              e_kind;
  logic [VALUE_W-1:0] e_val;
  logic [LEN_W-1:0]   e_len;
  logic               e_stop;

  assign c     = q_rdata;
  assign q_pop = !q_stat.empty && (!out_valid_r || out_tready);

  // radix multiply-add with saturation, saturating length increment and digit check
  always_comb begin
    mac_kind = ((phase_r == PH_PFX) || (phase_r == PH_RDIG)) ? radix_r : KIND_DEC;
    acc_w    = 36'(acc_r);
    unique case (mac_kind)
      KIND_BIN: prod = acc_w << 1;
      KIND_OCT: prod = acc_w << 3;
      KIND_HEX: prod = acc_w << 4;
      default:  prod = (acc_w << 3) + (acc_w << 1);
    endcase
    sum     = prod + 36'(c.dig);
    mac_val = (sum > 36'(VALUE_MAX)) ? VALUE_MAX : sum[VALUE_W-1:0];
    cnt_inc = (cnt_r == LEN_MAX) ? cnt_r : LEN_W'(cnt_r + 1'b1);
    unique case (radix_r)
      KIND_BIN: d_ok = c.is_dec && (c.dig[3:1] == 3'd0);
      KIND_OCT: d_ok = c.is_dec && !c.dig[3];
      KIND_HEX: d_ok = c.is_hex;
      default:  d_ok = c.is_dec;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    e_kind    = radix_r;
    e_val     = acc_r;
    e_len     = cnt_r;
    e_stop    = 1'b0;

    unique case (phase_r)
      PH_START: begin
        if (c.is_zero) begin
          phase_nxt = PH_ZERO;
        end else if (c.is_dec) begin
          acc_nxt   = mac_val;
          cnt_nxt   = cnt_inc;
          phase_nxt = PH_DDIG;
        end else begin
          emit   = 1'b1;
          e_kind = KIND_NAN;
          e_val  = '0;
          e_len  = '0;
          e_stop = 1'b1;
        end
      end
      PH_PFX, PH_RDIG: begin
        // underscores are skipped only right after the prefix
        priority if (phase_r == PH_PFX && c.is_us) begin
        end else if (d_ok) begin
          acc_nxt   = mac_val;
          cnt_nxt   = cnt_inc;
          phase_nxt = PH_RDIG;
        end else if (c.is_ident) begin
          emit   = 1'b1;
          e_kind = KIND_ERR;
          e_val  = '0;
          e_len  = '0;
        end else begin
          emit   = 1'b1;
          e_stop = 1'b1;
        end
      end
      PH_FRAC: begin
        if (c.is_dec) begin
          cnt_nxt = cnt_inc;
        end else if (c.is_ident) begin
          emit   = 1'b1;
          e_kind = KIND_ERR;
          e_val  = '0;
          e_len  = '0;
        end else begin
          emit   = 1'b1;
          e_stop = 1'b1;
        end
      end
      PH_ZERO, PH_LEADZ, PH_DDIG: begin
        priority if (phase_r == PH_ZERO && c.is_b) begin
          radix_nxt = KIND_BIN;
          phase_nxt = PH_PFX;
        end else if (phase_r == PH_ZERO && c.is_o) begin
          radix_nxt = KIND_OCT;
          phase_nxt = PH_PFX;
        end else if (phase_r == PH_ZERO && c.is_x) begin
          radix_nxt = KIND_HEX;
          phase_nxt = PH_PFX;
        end else if (c.is_zero && phase_r != PH_DDIG) begin
          phase_nxt = PH_LEADZ;
        end else if (c.is_dec) begin
          acc_nxt   = mac_val;
          cnt_nxt   = cnt_inc;
          phase_nxt = PH_DDIG;
        end else if (c.is_dot) begin
          radix_nxt = KIND_FLOAT;
          cnt_nxt   = cnt_inc;
          phase_nxt = PH_FRAC;
        end else if (c.is_ident) begin
          emit   = 1'b1;
          e_kind = KIND_ERR;
          e_val  = '0;
          e_len  = '0;
        end else begin
          emit   = 1'b1;
          e_stop = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase

    // end of text closes a literal that took this character
    if (!emit && c.last) begin
      emit   = 1'b1;
      e_kind = radix_nxt;
      e_val  = acc_nxt;
      e_len  = cnt_nxt;
      e_stop = 1'b0;
    end

    if (emit) begin
      phase_nxt = PH_START;
      radix_nxt = KIND_DEC;
      acc_nxt   = '0;
      cnt_nxt   = '0;
    end

    if (q_pop) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      radix_r     <= KIND_DEC;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_kind_r <= e_kind;
      out_val_r  <= e_val;
      out_len_r  <= e_len;
      out_stop_r <= e_stop;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_stop_r, out_len_r, out_val_r};
  assign out_tuser  = out_kind_r;

endmodule

### rtl/numeric_literal_scanner.sv
// ----------------------------------------------------------------------------
// numeric_literal_scanner
// Scans numeric literals from a character stream, one character per transaction.
// ----------------------------------------------------------------------------
// Takes one character per cycle with no gaps, and may stall only when the result
// side is stalled. A character goes through a classifier into a two-entry queue,
// and the scanner pops one entry per cycle unless the result side is stalled; a
// result is registered when the scanner pops the character that ends the literal.
// That rate is set by the scanner's radix multiply-add and saturate on its
// accumulator register. At most one result per character; after a result the
// next character starts a new literal. There is no start-up pass after reset.
`include "numeric_literal_scanner_macros.svh"

module numeric_literal_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [30:0] value, [38:31] length, [39] stopped_by_delimiter
  output logic [2:0]  out_tuser   // [2:0] kind
);
  import nls_pkg::*;

  qstat_t q_stat;
  cls_t   q_wdata, q_rdata;
  logic   q_push, q_pop;

  nls_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  nls_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  nls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `NLS_ASSERT_IMP(a_err_zero, clk, rst_n,
    out_tvalid && out_tuser == KIND_ERR,
    out_tdata[38:0] == 39'd0 && !out_tdata[39],
    "error result carries value or length")
  `NLS_ASSERT_IMP(a_nan_stop, clk, rst_n,
    out_tvalid && out_tuser == KIND_NAN,
    out_tdata[39] && out_tdata[38:0] == 39'd0,
    "not-a-number result malformed")
  `NLS_ASSERT_IMP(a_len_val, clk, rst_n,
    out_tvalid && out_tdata[38:31] == 8'd0,
    out_tdata[30:0] == 31'd0,
    "nonzero value with zero length")
  `NLS_ASSERT_NXT(a_q_fill, clk, rst_n,
    in_tvalid && in_tready && q_stat.empty,
    !q_stat.empty,
    "accepted character lost from queue")

endmodule
